[hdl/obtob_pkg.sv]
// ----------------------------------------------------------------------------
// obtob_pkg
// Shared constants and types for the top-of-book tracker.
// ----------------------------------------------------------------------------
package obtob_pkg;

	localparam int LEVELS         = 64;
	localparam int IDX_BITS       = $clog2(LEVELS);
	localparam int PRICE_BITS     = 48;
	localparam int QTY_BITS       = 48;
	// best-price tree: first stage reduces each group, second stage the groups
	localparam int SCAN_GROUPS    = 8;
	localparam int SCAN_GROUP_LEN = LEVELS / SCAN_GROUPS;

	typedef logic [PRICE_BITS-1:0] price_t;
	typedef logic [QTY_BITS-1:0]   qty_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	typedef struct packed {
		logic   vld;
		price_t px;
	} cand_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic match;
		logic update;
		logic report;
	} cmd_t;

endpackage

[hdl/obtob_ctrl.sv]
// ----------------------------------------------------------------------------
// obtob_ctrl
// Sequencer: load, match/search, table update + best-price scan, report.
// ----------------------------------------------------------------------------
module obtob_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output obtob_pkg::cmd_t cmd
);
	import obtob_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_MATCH;
			ST_MATCH:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_REPORT;
			ST_REPORT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd    = '0;
		busy   = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:   cmd.load   = start;
			ST_MATCH:  cmd.match  = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			ST_REPORT: cmd.report = 1'b1;
			default:   cmd        = '0;
		endcase
	end

`ifndef SYNTH
	a_seq_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.match) else $error("load not followed by match");
	a_seq_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match |=> cmd.update) else $error("match not followed by update");
	a_seq_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> cmd.report) else $error("update not followed by report");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one command");
`endif
endmodule

[hdl/obtob_dp.sv]
// ----------------------------------------------------------------------------
// obtob_dp
// Level tables, registered match/free search, two-stage best-price tree.
// ----------------------------------------------------------------------------
module obtob_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  obtob_pkg::cmd_t    cmd,
	input  logic               is_ask,
	input  obtob_pkg::price_t  level_price,
	input  obtob_pkg::qty_t    level_qty,
	output logic               strobe,
	output obtob_pkg::price_t  best_bid,
	output obtob_pkg::price_t  best_ask,
	output logic               side_full
);
	import obtob_pkg::*;

	// row 0 = bids, row 1 = asks
	price_t    price_q [2][LEVELS];
	qty_t      qtys_q  [2][LEVELS];
	logic [LEVELS-1:0] valid_q [2];

	logic   ask_q;
	price_t pr_q;
	qty_t   qt_q;

	logic   hit_s1, free_s1;
	idx_t   hit_idx_s1, free_idx_s1;

	cand_t  grp_q [2][SCAN_GROUPS];

	price_t bb_q, ba_q;
	logic   full_q;

	// better of two candidates; low price wins on the ask side
	function automatic cand_t pick(cand_t a, cand_t b, logic want_low);
		cand_t r;
		if (!b.vld) r = a;
		else if (!a.vld) r = b;
		else if (want_low ? (b.px < a.px) : (b.px > a.px)) r = b;
		else r = a;
		return r;
	endfunction

	// first matching valid slot and first free slot of the selected side
	logic hit_c, free_c;
	idx_t hit_idx_c, free_idx_c;
	always_comb begin
		hit_c = 1'b0; free_c = 1'b0;
		hit_idx_c = '0; free_idx_c = '0;
		for (int i = LEVELS-1; i >= 0; i--) begin
			if (valid_q[ask_q][i] && price_q[ask_q][i] == pr_q) begin
				hit_c = 1'b1; hit_idx_c = idx_t'(i);
			end
			if (!valid_q[ask_q][i]) begin
				free_c = 1'b1; free_idx_c = idx_t'(i);
			end
		end
	end

	// table contents as they stand after this update's write
	cand_t nxt_c [2][LEVELS];
	always_comb begin
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < LEVELS; i++) begin
				nxt_c[s][i].vld = valid_q[s][i];
				nxt_c[s][i].px  = price_q[s][i];
				if (ask_q == 1'(s)) begin
					if (qt_q == '0 && hit_s1 && hit_idx_s1 == idx_t'(i))
						nxt_c[s][i].vld = 1'b0;
					if (qt_q != '0 && !hit_s1 && free_s1 && free_idx_s1 == idx_t'(i)) begin
						nxt_c[s][i].vld = 1'b1;
						nxt_c[s][i].px  = pr_q;
					end
				end
			end
	end

	// first tree stage: best of each group
	cand_t grp_c [2][SCAN_GROUPS];
	always_comb begin
		cand_t tr [SCAN_GROUP_LEN];
		for (int s = 0; s < 2; s++)
			for (int g = 0; g < SCAN_GROUPS; g++) begin
				for (int j = 0; j < SCAN_GROUP_LEN; j++)
					tr[j] = nxt_c[s][g * SCAN_GROUP_LEN + j];
				for (int w = SCAN_GROUP_LEN / 2; w >= 1; w = w / 2)
					for (int k = 0; k < w; k++)
						tr[k] = pick(tr[2 * k], tr[2 * k + 1], s == 1);
				grp_c[s][g] = tr[0];
			end
	end

	// second tree stage: best of the registered groups
	cand_t best_c [2];
	always_comb begin
		cand_t tr [SCAN_GROUPS];
		for (int s = 0; s < 2; s++) begin
			for (int g = 0; g < SCAN_GROUPS; g++)
				tr[g] = grp_q[s][g];
			for (int w = SCAN_GROUPS / 2; w >= 1; w = w / 2)
				for (int k = 0; k < w; k++)
					tr[k] = pick(tr[2 * k], tr[2 * k + 1], s == 1);
			best_c[s] = tr[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ask_q <= is_ask;
			pr_q  <= level_price;
			qt_q  <= level_qty;
		end
		if (cmd.match) begin
			hit_s1      <= hit_c;
			free_s1     <= free_c;
			hit_idx_s1  <= hit_idx_c;
			free_idx_s1 <= free_idx_c;
		end
		if (cmd.update) begin
			full_q <= (qt_q != '0) && !hit_s1 && !free_s1;
			grp_q  <= grp_c;
			if (qt_q != '0) begin
				if (hit_s1) qtys_q[ask_q][hit_idx_s1] <= qt_q;
				else if (free_s1) begin
					price_q[ask_q][free_idx_s1] <= pr_q;
					qtys_q[ask_q][free_idx_s1]  <= qt_q;
				end
			end
		end
		if (cmd.report) begin
			bb_q <= best_c[0].vld ? best_c[0].px : '0;
			ba_q <= best_c[1].vld ? best_c[1].px : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q[0] <= '0;
			valid_q[1] <= '0;
			strobe     <= 1'b0;
		end else begin
			strobe <= cmd.report;
			if (cmd.update) begin
				if (qt_q == '0) begin
					if (hit_s1) valid_q[ask_q][hit_idx_s1] <= 1'b0;
				end else if (!hit_s1 && free_s1) begin
					valid_q[ask_q][free_idx_s1] <= 1'b1;
				end
			end
		end
	end

	assign best_bid  = bb_q;
	assign best_ask  = ba_q;
	assign side_full = full_q;

`ifndef SYNTH
	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && qt_q == '0 |=> !full_q) else $error("remove flagged full");
	a_full_means_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && (qt_q != '0) && !hit_s1 && !free_s1 |-> &valid_q[ask_q])
		else $error("full flagged with free slot");
	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && (qt_q != '0) && !hit_s1 && free_s1
		|=> valid_q[ask_q][free_idx_s1]) else $error("insert lost");
`endif
endmodule

[hdl/order_book_top_of_book.sv]
// ----------------------------------------------------------------------------
// order_book_top_of_book
// Best bid / best ask tracker over two 64-level price tables.
// ----------------------------------------------------------------------------
// Sequence: start is taken in idle (load), then match search, table write with
// group scan, final scan across groups (report); strobe is registered from report.
// busy is high until the report state is over, so no new word is taken before
// the last one is through; results cannot be stalled.
// Reset clears all valid bits and the sequencer at once; no clearing pass.
module order_book_top_of_book (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 is_ask,
	input  obtob_pkg::price_t    level_price,
	input  obtob_pkg::qty_t      level_qty,
	output logic                 strobe,
	output obtob_pkg::price_t    best_bid,
	output obtob_pkg::price_t    best_ask,
	output logic                 side_full
);
	import obtob_pkg::*;

	cmd_t cmd;

	obtob_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	obtob_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.is_ask      (is_ask),
		.level_price (level_price),
		.level_qty   (level_qty),
		.strobe      (strobe),
		.best_bid    (best_bid),
		.best_ask    (best_ask),
		.side_full   (side_full)
	);
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives level changes into the top-of-book tracker and checks every result
// word against a local model of both price tables.
// ----------------------------------------------------------------------------
module tb;
	import obtob_pkg::*;

	localparam int  MAX_CYCLES = 400000;
	localparam int  DRAIN      = 12;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	logic   is_ask;
	price_t level_price;
	qty_t   level_qty;
	logic   strobe;
	price_t best_bid;
	price_t best_ask;
	logic   side_full;

	order_book_top_of_book u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.is_ask(is_ask), .level_price(level_price), .level_qty(level_qty),
		.strobe(strobe), .best_bid(best_bid), .best_ask(best_ask),
		.side_full(side_full)
	);

	typedef struct {
		price_t bid;
		price_t ask;
		logic   full;
	} tob_t;

	// book model: [0] bids, [1] asks
	price_t book_px [2][LEVELS];
	logic   book_vld[2][LEVELS];
	tob_t   tob_q[$];
	int     n_err;
	int     n_words;
	int     n_results;
	int     cycles;
	int     burst_left;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic tob_t book_apply(logic side, price_t px, qty_t qty);
		tob_t r;
		int   hit;
		int   free_slot;
		logic any;
		hit = -1;
		free_slot = -1;
		r.full = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (book_vld[side][i]) begin
				if (hit < 0 && book_px[side][i] == px) hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		if (qty == 0) begin
			if (hit >= 0) book_vld[side][hit] = 1'b0;
		end else if (hit < 0) begin
			if (free_slot < 0) begin
				r.full = 1'b1;
			end else begin
				book_px[side][free_slot] = px;
				book_vld[side][free_slot] = 1'b1;
			end
		end
		r.bid = '0;
		any = 1'b0;
		for (int i = 0; i < LEVELS; i++)
			if (book_vld[0][i] && (!any || book_px[0][i] > r.bid)) begin
				r.bid = book_px[0][i];
				any = 1'b1;
			end
		r.ask = '0;
		any = 1'b0;
		for (int i = 0; i < LEVELS; i++)
			if (book_vld[1][i] && (!any || book_px[1][i] < r.ask)) begin
				r.ask = book_px[1][i];
				any = 1'b1;
			end
		return r;
	endfunction

	// drop start and put junk on the fields
	task automatic idle_bus();
		start <= 1'b0;
		is_ask <= 1'($urandom_range(0, 1));
		level_price <= price_t'({$urandom, $urandom});
		level_qty <= qty_t'({$urandom, $urandom});
	endtask

	// one word; sender gaps come in bursts
	task automatic send_level(logic side, price_t px, qty_t qty);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 9);
		end
		if (gap > 0) begin
			idle_bus();
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		start <= 1'b1;
		is_ask <= side;
		level_price <= px;
		level_qty <= qty;
		@(posedge clk);
		while (busy) @(posedge clk);
		tob_q.push_back(book_apply(side, px, qty));
		n_words++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		idle_bus();
		do @(negedge clk); while (tob_q.size() != 0);
	endtask

	always @(posedge clk) begin
		tob_t e;
		if (arst_n && strobe) begin
			n_results++;
			if (tob_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("ERROR: unexpected result word");
			end else begin
				e = tob_q.pop_front();
				if (best_bid !== e.bid || best_ask !== e.ask || side_full !== e.full) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR: exp bid %h ask %h full %b, got bid %h ask %h full %b",
							e.bid, e.ask, e.full, best_bid, best_ask, side_full);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Timeout");
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_extremes();
		send_level(1'b0, '0, '0);            // remove absent bid
		send_level(1'b1, '1, '0);            // remove absent ask
		send_level(1'b0, '0, 48'd5);         // bid at price zero
		send_level(1'b1, '0, '1);            // ask at price zero
		send_level(1'b0, '1, 48'h1);
		send_level(1'b1, '1, '1);
		send_level(1'b0, '1, 48'h7);         // overwrite
		send_level(1'b0, '1, '0);
		send_level(1'b1, '0, '0);
		send_level(1'b0, '0, '0);
		send_level(1'b1, '1, '0);
		send_level(1'b0, 48'haaaa_aaaa_aaaa, 48'h5555_5555_5555);
		send_level(1'b1, 48'h5555_5555_5555, 48'haaaa_aaaa_aaaa);
		wait_drained();
	endtask

	// fill a side, overflow it, overwrite while full, then empty it
	task automatic test_full_side(logic side);
		for (int i = 0; i < LEVELS; i++) send_level(side, price_t'(1000 + i * 3), 48'd1);
		send_level(side, price_t'(5), 48'd2);
		send_level(side, '1, 48'd2);
		send_level(side, price_t'(1000), 48'd9);
		for (int i = 0; i < LEVELS; i++) send_level(side, price_t'(1000 + i * 3), '0);
		wait_drained();
	endtask

	task automatic test_random(int count);
		logic   side;
		price_t px;
		qty_t   qty;
		int     mode;
		for (int n = 0; n < count; n++) begin
			side = 1'($urandom_range(0, 1));
			mode = $urandom_range(0, 9);
			// narrow price band so levels are hit again and tables fill up
			if (mode < 8) px = price_t'(100 + $urandom_range(0, 90));
			else px = price_t'({$urandom, $urandom});
			qty = ($urandom_range(0, 3) == 0) ? '0 : qty_t'({$urandom, $urandom});
			send_level(side, px, qty);
			if (n % 500 == 250) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		is_ask = 1'b0;
		level_price = '0;
		level_qty = '0;
		n_err = 0;
		n_words = 0;
		n_results = 0;
		cycles = 0;
		burst_left = 0;
		for (int s = 0; s < 2; s++)
			for (int i = 0; i < LEVELS; i++) begin
				book_px[s][i] = '0;
				book_vld[s][i] = 1'b0;
			end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_full_side(1'b0);
		test_full_side(1'b1);
		test_random(1250);
		repeat (DRAIN) @(negedge clk);
		$display("Sent %0d level changes (extremes, full sides, random), checked %0d results",
			n_words, n_results);
		if (n_err == 0 && tob_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Mismatches: %0d", n_err);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
